// ===== rtl/id_slot_table_allocator_unit_macros.svh =====
// Assertion macros for the slot table RTL.
`ifndef ID_SLOT_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define ID_SLOT_TABLE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ISATU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot table check failed");

// Next-cycle implication.
`define ISATU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot table check failed");

`else

`define ISATU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ISATU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/isatu_pkg.sv =====
package isatu_pkg;

   localparam int SLOTS_DEFAULT   = 64;
   localparam int ID_WIDTH        = 32;
   localparam int DATA_WIDTH      = 32;
   localparam int OP_WIDTH        = 2;
   localparam int LIVE_WIDTH      = 7;
   localparam int REQ_TDATA_WIDTH = 64;
   localparam int RSP_TDATA_WIDTH = 80;
   localparam int RSP_PAD_WIDTH   = RSP_TDATA_WIDTH - (2 * ID_WIDTH + 2 + LIVE_WIDTH);

   localparam logic [OP_WIDTH-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_LOOKUP = 2'd2;

   localparam int STEP_WIDTH = 4;
   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type S_CLEAR   = 4'd0;
   localparam step_type S_FETCH   = 4'd1;
   localparam step_type S_PRB_RD  = 4'd2;
   localparam step_type S_PRB_CHK = 4'd3;
   localparam step_type S_MOD     = 4'd4;
   localparam step_type S_RMV_RD  = 4'd5;
   localparam step_type S_RMV     = 4'd6;
   localparam step_type S_LKP_RD  = 4'd7;
   localparam step_type S_LKP     = 4'd8;
   localparam step_type S_RESPOND = 4'd9;

   typedef logic [2:0] cond_type;
   localparam cond_type C_GOTO  = 3'd0;
   localparam cond_type C_CLR   = 3'd1;
   localparam cond_type C_REQ   = 3'd2;
   localparam cond_type C_MOD   = 3'd3;
   localparam cond_type C_PROBE = 3'd4;
   localparam cond_type C_RSP   = 3'd5;

   typedef logic [1:0] addr_src_type;
   localparam addr_src_type A_CLR  = 2'd0;
   localparam addr_src_type A_DRAW = 2'd1;
   localparam addr_src_type A_REQ  = 2'd2;

   typedef struct packed {
      logic         take_req;
      logic         clear;
      logic         probe;
      logic         remove;
      logic         lookup_take;
      logic         rsp_load;
      addr_src_type addr_src;
      cond_type     cond;
      step_type     target;
   } uword_type;

   // Control store: one word per step.
   function automatic uword_type ucode(input step_type step);
      uword_type uw;
      uw = '0;
      uw.addr_src = A_REQ;
      uw.cond     = C_GOTO;
      uw.target   = S_FETCH;
      unique case (step)
         S_CLEAR: begin
            uw.clear    = 1'b1;
            uw.addr_src = A_CLR;
            uw.cond     = C_CLR;
            uw.target   = S_FETCH;
         end
         S_FETCH: begin
            uw.take_req = 1'b1;
            uw.cond     = C_REQ;
         end
         S_PRB_RD: begin
            uw.addr_src = A_DRAW;
            uw.target   = S_PRB_CHK;
         end
         S_PRB_CHK: begin
            uw.probe    = 1'b1;
            uw.addr_src = A_DRAW;
            uw.cond     = C_PROBE;
            uw.target   = S_RESPOND;
         end
         S_MOD: begin
            uw.cond = C_MOD;
         end
         S_RMV_RD: begin
            uw.target = S_RMV;
         end
         S_RMV: begin
            uw.remove = 1'b1;
            uw.target = S_RESPOND;
         end
         S_LKP_RD: begin
            uw.target = S_LKP;
         end
         S_LKP: begin
            uw.lookup_take = 1'b1;
            uw.target      = S_RESPOND;
         end
         S_RESPOND: begin
            uw.rsp_load = 1'b1;
            uw.cond     = C_RSP;
            uw.target   = S_FETCH;
         end
         default: begin
            uw.target = S_FETCH;
         end
      endcase
      return uw;
   endfunction

endpackage

// ===== rtl/isatu_ram.sv =====
module isatu_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/isatu_mod.sv =====
// Slot index of an id: id mod SLOTS. A power of two registers the low bits; any other size
// registers a reciprocal multiply for the quotient estimate, then one correcting subtract.
module isatu_mod import isatu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ID_WIDTH-1:0]      id,
   output logic                     done,
   output logic [$clog2(SLOTS)-1:0] slot
);

   localparam int IW = $clog2(SLOTS);

   logic          done_ff;
   logic [IW-1:0] rem_ff;

   generate
      if ((1 << IW) == SLOTS) begin : g_mask
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= id[IW-1:0];
            end
         end
      end else begin : g_recip
         // floor(2^(31+IW) / SLOTS) fits 32 bits; the quotient estimate is low by at most one
         localparam int QS = ID_WIDTH - 1 + IW;
         localparam logic [ID_WIDTH-1:0] MAGIC = ID_WIDTH'((64'd1 << QS) / 64'(SLOTS));

         logic                  busy_ff;
         logic [IW:0]           q_lo_ff;
         logic [IW:0]           id_lo_ff;
         logic [2*ID_WIDTH-1:0] prod;
         logic [IW:0]           back;
         logic [IW:0]           r_est;
         logic [IW:0]           r_sub;

         assign prod  = (2*ID_WIDTH)'(id) * (2*ID_WIDTH)'(MAGIC);
         // only the low bits matter: the estimated remainder stays below 2 * SLOTS
         assign back  = q_lo_ff * (IW+1)'(SLOTS);
         assign r_est = id_lo_ff - back;
         assign r_sub = r_est - (IW+1)'(SLOTS);

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               busy_ff <= start;
               done_ff <= busy_ff;
            end
            if (start) begin
               q_lo_ff  <= prod[QS +: IW+1];
               id_lo_ff <= id[IW:0];
            end
            if (busy_ff) begin
               rem_ff <= (r_est >= (IW+1)'(SLOTS)) ? r_sub[IW-1:0] : r_est[IW-1:0];
            end
         end
      end
   endgenerate

   assign done = done_ff;
   assign slot = rem_ff;

endmodule

// ===== rtl/id_slot_table_allocator_unit.sv =====
// Handle table of SLOTS slots. Add (op 0) draws ids from a running 32-bit counter that skips
// zero, probes slot id mod SLOTS and stores the word at the first empty slot, returning the id;
// after SLOTS occupied probes it reports status 1. Remove (op 1) frees the slot an id names and
// lookup (op 2) returns its word; neither compares the full id. Every word in gives one word out.
// After reset a clearing pass over all SLOTS slots runs before the first word is taken. Add
// reads each probed slot, then checks and writes it, as set by the single-port slot RAM. Remove
// and lookup wait on the id-to-slot remainder unit (reciprocal multiply, then one correcting
// subtract, where SLOTS is not a power of two), then read and act on the slot. A new word is
// taken while the previous result still waits on the output register.
`include "id_slot_table_allocator_unit_macros.svh"

module id_slot_table_allocator_unit import isatu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // entry_id [31:0], entry_data [63:32]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // op [1:0]
   input  logic [OP_WIDTH-1:0]        req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status [0], new_id [32:1], found [33], read_data [65:34], live_count [72:66], zero pad
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int MW = DATA_WIDTH + 1;

   step_type  step_ff, step_in;
   uword_type uw;

   logic [OP_WIDTH-1:0]   op_ff;
   logic [DATA_WIDTH-1:0] data_ff;
   logic [ID_WIDTH-1:0]   next_id_ff, next_id_in;
   logic [IW-1:0]         nslot_ff, nslot_in;
   logic [IW-1:0]         probe_ff, probe_in;
   logic [CW-1:0]         cnt_ff, cnt_in;

   logic                  res_status_ff;
   logic [ID_WIDTH-1:0]   res_new_id_ff;
   logic                  res_found_ff;
   logic [DATA_WIDTH-1:0] res_read_ff;

   logic                       rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;

   logic                req_acc;
   logic                mod_start;
   logic                mod_done;
   logic [IW-1:0]       mod_slot;
   logic [ID_WIDTH-1:0] cur_id;
   logic [ID_WIDTH-1:0] id_adv;
   logic [IW-1:0]       cur_slot;
   logic [IW:0]         slot_inc;
   logic [IW-1:0]       mem_addr;
   logic                mem_we;
   logic [MW-1:0]       mem_wdata;
   logic [MW-1:0]       mem_rdata;
   logic                rd_valid;
   logic                probe_hit;
   logic                probe_last;
   logic                rsp_go;
   logic [CW+LIVE_WIDTH-1:0] cnt_ext;

   assign uw         = ucode(step_ff);
   assign req_tready = uw.take_req;
   assign req_acc    = req_tvalid && req_tready;
   assign mod_start  = req_acc && (req_tuser == OP_REMOVE || req_tuser == OP_LOOKUP);

   isatu_mod #(.SLOTS(SLOTS)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .id    (req_tdata[ID_WIDTH-1:0]),
      .done  (mod_done),
      .slot  (mod_slot)
   );

   // id zero is never handed out: draw 1 instead
   assign cur_id   = (next_id_ff == '0) ? ID_WIDTH'(1) : next_id_ff;
   assign cur_slot = (next_id_ff == '0) ? IW'(1) : nslot_ff;
   assign id_adv   = cur_id + 1'b1;
   assign slot_inc = {1'b0, cur_slot} + 1'b1;

   always_comb begin
      if (id_adv == '0 || slot_inc == (IW+1)'(SLOTS)) begin
         nslot_in = '0;
      end else begin
         nslot_in = slot_inc[IW-1:0];
      end
   end

   always_comb begin
      unique case (uw.addr_src)
         A_CLR:   mem_addr = probe_ff;
         A_DRAW:  mem_addr = cur_slot;
         A_REQ:   mem_addr = mod_slot;
         default: mem_addr = mod_slot;
      endcase
   end

   assign rd_valid   = mem_rdata[DATA_WIDTH];
   assign probe_hit  = uw.probe && !rd_valid;
   assign probe_last = (probe_ff == IW'(SLOTS - 1));
   assign mem_we     = uw.clear || probe_hit || (uw.remove && rd_valid);
   assign mem_wdata  = probe_hit ? {1'b1, data_ff} : {1'b0, DATA_WIDTH'(0)};

   isatu_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      probe_in = probe_ff;
      if (uw.clear || uw.probe) begin
         probe_in = (probe_hit || probe_last) ? '0 : probe_ff + 1'b1;
      end
   end

   assign next_id_in = uw.probe ? id_adv : next_id_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (probe_hit) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (uw.remove && rd_valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign rsp_go = uw.rsp_load && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      step_in = step_ff;
      unique case (uw.cond)
         C_GOTO: begin
            step_in = uw.target;
         end
         C_CLR: begin
            if (probe_last) begin
               step_in = uw.target;
            end
         end
         C_REQ: begin
            if (req_acc) begin
               if (req_tuser == OP_ADD) begin
                  step_in = S_PRB_RD;
               end else if (mod_start) begin
                  step_in = S_MOD;
               end else begin
                  step_in = S_RESPOND;
               end
            end
         end
         C_MOD: begin
            if (mod_done) begin
               step_in = (op_ff == OP_REMOVE) ? S_RMV_RD : S_LKP_RD;
            end
         end
         C_PROBE: begin
            step_in = (probe_hit || probe_last) ? uw.target : S_PRB_RD;
         end
         C_RSP: begin
            if (rsp_go) begin
               step_in = uw.target;
            end
         end
         default: begin
            step_in = S_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= S_CLEAR;
         next_id_ff   <= '0;
         nslot_ff     <= '0;
         probe_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         next_id_ff <= next_id_in;
         probe_ff   <= probe_in;
         cnt_ff     <= cnt_in;
         if (uw.probe) begin
            nslot_ff <= nslot_in;
         end
         if (rsp_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign cnt_ext = {LIVE_WIDTH'(0), cnt_ff};

   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff         <= req_tuser;
         data_ff       <= req_tdata[ID_WIDTH +: DATA_WIDTH];
         res_status_ff <= 1'b0;
         res_new_id_ff <= '0;
         res_found_ff  <= 1'b0;
         res_read_ff   <= '0;
      end
      if (probe_hit) begin
         res_new_id_ff <= cur_id;
      end else if (uw.probe && probe_last) begin
         res_status_ff <= 1'b1;
      end
      if (uw.lookup_take) begin
         res_found_ff <= rd_valid;
         res_read_ff  <= rd_valid ? mem_rdata[DATA_WIDTH-1:0] : '0;
      end
      if (rsp_go) begin
         rsp_data_ff <= {RSP_PAD_WIDTH'(0), cnt_ext[LIVE_WIDTH-1:0], res_read_ff,
                         res_found_ff, res_new_id_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ISATU_ASSERT_IMPLIES(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CW'(SLOTS))
   `ISATU_ASSERT_IMPLIES(a_cnt_step, clock, reset, step_ff != S_CLEAR, cnt_ff == $past(cnt_ff) || cnt_ff == $past(cnt_ff) + 1'b1 || cnt_ff == $past(cnt_ff) - 1'b1)
   `ISATU_ASSERT_IMPLIES(a_mod_done_step, clock, reset, mod_done, step_ff == S_MOD)
   `ISATU_ASSERT_IMPLIES(a_fetch_no_write, clock, reset, step_ff == S_FETCH, !mem_we)
   `ISATU_ASSERT_NEXT(a_accept_leaves, clock, reset, req_acc, step_ff != S_FETCH)

endmodule

// ===== dv/id_slot_table_scoreboard.sv =====
`timescale 1ns / 100ps

module id_slot_table_scoreboard import isatu_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic [OP_WIDTH-1:0]        req_tuser,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output int unsigned                mismatches,
   output int unsigned                outstanding
);

   typedef struct packed {
      logic                  status;
      logic [ID_WIDTH-1:0]   new_id;
      logic                  found;
      logic [DATA_WIDTH-1:0] read_data;
      logic [LIVE_WIDTH-1:0] live_count;
   } slot_reply_type;

   logic [DATA_WIDTH-1:0] slot_word [SLOTS];
   bit                    slot_live [SLOTS];
   logic [ID_WIDTH-1:0]   id_counter;
   int unsigned           live_total;
   slot_reply_type        replies_due [$];
   int unsigned           fail_count = 0;
   int unsigned           due_count = 0;

   assign mismatches  = fail_count;
   assign outstanding = due_count;

   // Apply one request to the shadow table and return the reply it should produce.
   function automatic slot_reply_type apply_request(input logic [OP_WIDTH-1:0] op,
                                                    input logic [ID_WIDTH-1:0] id,
                                                    input logic [DATA_WIDTH-1:0] word);
      slot_reply_type      r;
      logic [ID_WIDTH-1:0] cand;
      int unsigned         slot;
      bit                  placed;
      r      = '0;
      placed = 1'b0;
      case (op)
         OP_ADD: begin
            for (int p = 0; p < SLOTS && !placed; p++) begin
               cand = id_counter;
               // skip zero: hand out 1 and move on to 2
               if (cand == '0) cand = ID_WIDTH'(1);
               id_counter = cand + 1'b1;
               slot = cand % SLOTS;
               if (!slot_live[slot]) begin
                  slot_live[slot] = 1'b1;
                  slot_word[slot] = word;
                  live_total++;
                  r.new_id = cand;
                  placed   = 1'b1;
               end
            end
            r.status = !placed;
         end
         OP_REMOVE: begin
            slot = id % SLOTS;
            if (slot_live[slot]) begin
               slot_live[slot] = 1'b0;
               live_total--;
            end
         end
         OP_LOOKUP: begin
            slot = id % SLOTS;
            if (slot_live[slot]) begin
               r.found     = 1'b1;
               r.read_data = slot_word[slot];
            end
         end
         default: ;
      endcase
      r.live_count = live_total[LIVE_WIDTH-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         fail_count++;
         if (fail_count <= 40)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
   endtask

   always @(posedge clock) begin : track
      slot_reply_type want;
      slot_reply_type seen;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_word[i] = '0;
         end
         id_counter = '0;
         live_total = 0;
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status     = rsp_tdata[0];
            seen.new_id     = rsp_tdata[32:1];
            seen.found      = rsp_tdata[33];
            seen.read_data  = rsp_tdata[65:34];
            seen.live_count = rsp_tdata[72:66];
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: unexpected reply word, expected none, actual %0h",
                           $time, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               check_field("status", want.status, seen.status);
               check_field("new_id", want.new_id, seen.new_id);
               check_field("found", want.found, seen.found);
               check_field("read_data", want.read_data, seen.read_data);
               check_field("live_count", want.live_count, seen.live_count);
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(apply_request(req_tuser, req_tdata[31:0], req_tdata[63:32]));
      end
      due_count = replies_due.size();
   end

endmodule

// ===== dv/tb_id_slot_table_allocator_unit.sv =====
`timescale 1ns / 100ps

module tb_id_slot_table_allocator_unit;
   import isatu_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [OP_WIDTH-1:0]        req_tuser = OP_ADD;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   int unsigned      check_errors;
   int unsigned      replies_pending;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      words_sent = 0;
   int unsigned      words_back = 0;
   int unsigned      adds_refused = 0;
   int unsigned      op_tally [4] = '{0, 0, 0, 0};
   logic [SLOTS-1:0] slot_written = '0;

   always #4 clock = ~clock;

   id_slot_table_allocator_unit #(.SLOTS(SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   id_slot_table_scoreboard #(.SLOTS(SLOTS)) i_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (check_errors),
      .outstanding (replies_pending)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Note slots that have held a word, so lookups never read a slot never written.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_back++;
         if (rsp_tdata[0]) adds_refused++;
         if (rsp_tdata[32:1] != '0) slot_written[rsp_tdata[32:1] % SLOTS] <= 1'b1;
      end
   end

   task automatic issue(input logic [OP_WIDTH-1:0] op, input logic [ID_WIDTH-1:0] id,
                        input logic [DATA_WIDTH-1:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {word, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      op_tally[op]++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (words_back == words_sent);
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 14;
      recv_stall_pct = 61;

      issue(OP_UNUSED, '1, '1);
      issue(OP_REMOVE, '0, $urandom);
      issue(OP_ADD, $urandom, '0);
      issue(OP_ADD, $urandom, '1);
      repeat (3) issue(OP_ADD, $urandom, $urandom);
      drain();
      issue(OP_LOOKUP, 32'd1, $urandom);
      // stale id: every high bit set, same slot as id 1
      issue(OP_LOOKUP, 32'hFFFF_FFC1, $urandom);
      issue(OP_LOOKUP, 32'd2, $urandom);
      issue(OP_REMOVE, 32'h0000_0042, $urandom);
      issue(OP_LOOKUP, 32'd2, $urandom);
      issue(OP_REMOVE, 32'd2, $urandom);
      issue(OP_ADD, $urandom, $urandom);
      issue(OP_UNUSED, '0, '0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 61 : 0;
         recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 14 : 0;
         for (int k = 0; k < 134; k++) begin : one_word
            logic [OP_WIDTH-1:0] kind;
            logic [ID_WIDTH-1:0] rid;
            int unsigned         pick;
            int unsigned         start;
            int unsigned         s;
            bit                  hit;
            pick = $urandom_range(0, 99);
            rid  = $urandom;
            hit  = 1'b0;
            // fill toward a full table first, then drain it
            if (k < 90)
               kind = (pick < 88) ? OP_ADD : (pick < 92) ? OP_REMOVE :
                      (pick < 98) ? OP_LOOKUP : OP_UNUSED;
            else
               kind = (pick < 20) ? OP_ADD : (pick < 70) ? OP_REMOVE :
                      (pick < 96) ? OP_LOOKUP : OP_UNUSED;
            if (kind == OP_LOOKUP) begin
               start = $urandom_range(0, SLOTS - 1);
               for (int j = 0; j < SLOTS && !hit; j++) begin
                  s = (start + j) % SLOTS;
                  if (slot_written[s]) begin
                     hit = 1'b1;
                     rid = rid - (rid % SLOTS) + s;
                  end
               end
               if (!hit) kind = OP_ADD;
            end
            issue(kind, rid, $urandom);
         end
      end

      drain();
      repeat (40) @(posedge clock);

      $display("Drove %0d words: %0d adds, %0d removes, %0d lookups, %0d unused-op words",
               words_sent, op_tally[OP_ADD], op_tally[OP_REMOVE], op_tally[OP_LOOKUP],
               op_tally[OP_UNUSED]);
      $display("%0d adds refused on a full table, across three sender/receiver stall mixes",
               adds_refused);
      if (check_errors == 0 && replies_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/isatu_pkg.sv
rtl/isatu_ram.sv
rtl/isatu_mod.sv
rtl/id_slot_table_allocator_unit.sv
dv/id_slot_table_scoreboard.sv
dv/tb_id_slot_table_allocator_unit.sv
